[hdl/jsesc_pkg.sv]
// Package for the JSON string escaper with UTF-8 checking.
// Holds byte constants and the hex digit lookup.
// No dependencies.
package jsesc_pkg;

  // Escaped literal punctuation
  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_U = 8'h75;
  localparam logic [7:0] CHAR_0 = 8'h30;

  // Short escape letters
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_F = 8'h66;
  localparam logic [7:0] CHAR_N = 8'h6E;
  localparam logic [7:0] CHAR_R = 8'h72;
  localparam logic [7:0] CHAR_T = 8'h74;

  // Control bytes with short escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_CR = 8'h0D;

  // UTF-8 ranges and second-byte limits
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] ASCII_END = 8'h80;
  localparam logic [7:0] LEAD2_LO  = 8'hC2;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD_ED   = 8'hED;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF4;
  localparam logic [7:0] CONT_A0   = 8'hA0;
  localparam logic [7:0] CONT_90   = 8'h90;

  // U+FFFD replacement character
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Longest body of one byte: a \u00XX escape
  localparam int unsigned MAIN_DEPTH = 6;

  // Lowercase hex digit of a nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h57 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

[hdl/json_string_escaper_utf8_unit.sv]
// Top level of the JSON string escaper with UTF-8 checking.
// Uses jsesc_pkg for byte constants and the hex digit lookup.
// Each input transfer registers a result plan that is drained into the output register.
// Throughput: one input transfer per cycle while each byte yields one result
// and the output is ready; an item that yields k result bytes (1..16) holds off
// the next input until the single output register takes its last result byte.
// Reset (rst_ni low, asynchronous) closes any open string and drops held bytes.
module json_string_escaper_utf8_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] has_byte
  input  logic       s_axis_tlast_i,   // end_of_string
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] closes_string
  output logic       m_axis_tlast_o    // last_in_run
);

  // Output sections of one item, in emission order
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_OPEN  = 3'd1,
    PH_PRE   = 3'd2,
    PH_MAIN  = 3'd3,
    PH_POST  = 3'd4,
    PH_CLOSE = 3'd5,
    PH_IDLE  = 3'd6
  } phase_e;

  // First non-empty section after p
  function automatic phase_e next_phase(input phase_e p, input logic op,
                                        input logic [2:0] pre, input logic [2:0] ml,
                                        input logic [1:0] po, input logic cl);
    phase_e r;
    r = PH_IDLE;
    if (cl && (p < PH_CLOSE)) r = PH_CLOSE;
    if ((po != 2'd0) && (p < PH_POST)) r = PH_POST;
    if ((ml != 3'd0) && (p < PH_MAIN)) r = PH_MAIN;
    if ((pre != 3'd0) && (p < PH_PRE)) r = PH_PRE;
    if (op && (p < PH_OPEN)) r = PH_OPEN;
    return r;
  endfunction

  // String state
  logic [7:0] held_q [0:2];
  logic [7:0] held_d [0:2];
  logic [1:0] hc_q, hc_d;
  logic [2:0] sl_q, sl_d;
  logic       ins_q, ins_d;

  // Result plan of the current item
  logic       open_q, open_d;
  logic [2:0] pre_q, pre_d;
  logic [7:0] main_q [0:jsesc_pkg::MAIN_DEPTH-1];
  logic [7:0] main_d [0:jsesc_pkg::MAIN_DEPTH-1];
  logic [2:0] ml_q, ml_d;
  logic [1:0] post_q, post_d;
  logic       close_q, close_d;

  // Drain sequencer and output register
  phase_e     phase_q;
  logic [2:0] cnt_q;
  logic [1:0] sub_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       out_close_q;

  logic       accept;
  logic       busy;
  logic       out_ready;
  logic       emit;
  logic       ph_last;
  phase_e     ph_after;
  logic       job_last;
  logic [7:0] emit_byte;

  // Plan the results of an incoming byte and the next string state
  always_comb begin
    logic [7:0] b;
    logic [1:0] hc;
    logic [2:0] sl;
    logic       ok;
    logic       scan;
    b    = s_axis_tdata_i;
    hc   = ins_q ? hc_q : 2'd0;
    sl   = ins_q ? sl_q : 3'd0;
    ok   = 1'b0;
    scan = 1'b0;
    for (int k = 0; k < 3; k++) begin
      held_d[k] = held_q[k];
    end
    for (int k = 0; k < jsesc_pkg::MAIN_DEPTH; k++) begin
      main_d[k] = jsesc_pkg::CHAR_0;
    end
    hc_d    = hc;
    sl_d    = sl;
    ins_d   = ins_q;
    open_d  = 1'b0;
    pre_d   = 3'd0;
    ml_d    = 3'd0;
    post_d  = 2'd0;
    close_d = 1'b0;

    if (s_axis_tuser_i || s_axis_tlast_i) begin
      open_d = ~ins_q;
      ins_d  = 1'b1;
    end

    if (s_axis_tuser_i) begin
      if (hc != 2'd0) begin
        // Check a continuation byte against the held lead
        ok = (b[7:6] == 2'b10);
        if (hc == 2'd1) begin
          if ((held_q[0] == jsesc_pkg::LEAD3_LO) && (b < jsesc_pkg::CONT_A0)) ok = 1'b0;
          if ((held_q[0] == jsesc_pkg::LEAD_ED) && (b >= jsesc_pkg::CONT_A0)) ok = 1'b0;
          if ((held_q[0] == jsesc_pkg::LEAD4_LO) && (b < jsesc_pkg::CONT_90)) ok = 1'b0;
          if ((held_q[0] == jsesc_pkg::LEAD4_HI) && (b >= jsesc_pkg::CONT_90)) ok = 1'b0;
        end
        if (!ok) begin
          // Replace every held byte, then rescan this one
          pre_d = {1'b0, hc};
          hc_d  = 2'd0;
          sl_d  = 3'd0;
          scan  = 1'b1;
        end else if ((({1'b0, hc} + 3'd1) >= sl) || (hc == 2'd3)) begin
          // Sequence complete: pass held bytes and this one
          main_d[0] = held_q[0];
          main_d[1] = (hc > 2'd1) ? held_q[1] : b;
          main_d[2] = (hc > 2'd2) ? held_q[2] : b;
          main_d[3] = b;
          ml_d      = {1'b0, hc} + 3'd1;
          hc_d      = 2'd0;
          sl_d      = 3'd0;
        end else begin
          held_d[hc] = b;
          hc_d       = hc + 2'd1;
        end
      end else begin
        scan = 1'b1;
      end

      if (scan) begin
        if ((b >= jsesc_pkg::PRINT_LO) && (b < jsesc_pkg::ASCII_END) &&
            (b != jsesc_pkg::QUOTE) && (b != jsesc_pkg::BSLASH)) begin
          main_d[0] = b;
          ml_d      = 3'd1;
        end else if (b < jsesc_pkg::PRINT_LO) begin
          main_d[0] = jsesc_pkg::BSLASH;
          ml_d      = 3'd2;
          case (b)
            jsesc_pkg::CTL_BS: main_d[1] = jsesc_pkg::CHAR_B;
            jsesc_pkg::CTL_FF: main_d[1] = jsesc_pkg::CHAR_F;
            jsesc_pkg::CTL_LF: main_d[1] = jsesc_pkg::CHAR_N;
            jsesc_pkg::CTL_CR: main_d[1] = jsesc_pkg::CHAR_R;
            jsesc_pkg::CTL_HT: main_d[1] = jsesc_pkg::CHAR_T;
            default: begin
              main_d[1] = jsesc_pkg::CHAR_U;
              main_d[2] = jsesc_pkg::CHAR_0;
              main_d[3] = jsesc_pkg::CHAR_0;
              main_d[4] = jsesc_pkg::hex_digit(b[7:4]);
              main_d[5] = jsesc_pkg::hex_digit(b[3:0]);
              ml_d      = 3'd6;
            end
          endcase
        end else if ((b == jsesc_pkg::QUOTE) || (b == jsesc_pkg::BSLASH)) begin
          main_d[0] = jsesc_pkg::BSLASH;
          main_d[1] = b;
          ml_d      = 3'd2;
        end else if ((b >= jsesc_pkg::LEAD2_LO) && (b < jsesc_pkg::LEAD3_LO)) begin
          held_d[0] = b;
          hc_d      = 2'd1;
          sl_d      = 3'd2;
        end else if ((b >= jsesc_pkg::LEAD3_LO) && (b < jsesc_pkg::LEAD4_LO)) begin
          held_d[0] = b;
          hc_d      = 2'd1;
          sl_d      = 3'd3;
        end else if ((b >= jsesc_pkg::LEAD4_LO) && (b <= jsesc_pkg::LEAD4_HI)) begin
          held_d[0] = b;
          hc_d      = 2'd1;
          sl_d      = 3'd4;
        end else begin
          // Stray or invalid lead byte
          pre_d = pre_d + 3'd1;
        end
      end
    end

    // Flush truncated bytes and close the literal
    if (s_axis_tlast_i) begin
      post_d  = hc_d;
      close_d = 1'b1;
      hc_d    = 2'd0;
      sl_d    = 3'd0;
      ins_d   = 1'b0;
    end
  end

  // Select the byte of the current section and detect its end
  always_comb begin
    emit_byte = jsesc_pkg::QUOTE;
    ph_last   = 1'b1;
    unique case (phase_q)
      PH_OPEN, PH_CLOSE: begin
        emit_byte = jsesc_pkg::QUOTE;
        ph_last   = 1'b1;
      end
      PH_PRE, PH_POST: begin
        case (sub_q)
          2'd0:    emit_byte = jsesc_pkg::REPL_B0;
          2'd1:    emit_byte = jsesc_pkg::REPL_B1;
          default: emit_byte = jsesc_pkg::REPL_B2;
        endcase
        if (phase_q == PH_PRE) begin
          ph_last = (sub_q == 2'd2) && (cnt_q == (pre_q - 3'd1));
        end else begin
          ph_last = (sub_q == 2'd2) && (cnt_q == ({1'b0, post_q} - 3'd1));
        end
      end
      PH_MAIN: begin
        emit_byte = main_q[cnt_q];
        ph_last   = (cnt_q == (ml_q - 3'd1));
      end
      default: begin
        emit_byte = jsesc_pkg::QUOTE;
        ph_last   = 1'b1;
      end
    endcase
  end

  assign ph_after  = next_phase(phase_q, open_q, pre_q, ml_q, post_q, close_q);
  assign busy      = (phase_q != PH_IDLE);
  assign out_ready = ~out_valid_q | m_axis_tready_i;
  assign emit      = busy & out_ready;
  assign job_last  = emit & ph_last & (ph_after == PH_IDLE);
  assign s_axis_tready_o = ~busy | job_last;
  assign accept    = s_axis_tvalid_i & s_axis_tready_o;

  // Hold string state and sequencer; advance on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q        <= 2'd0;
      sl_q        <= 3'd0;
      ins_q       <= 1'b0;
      phase_q     <= PH_IDLE;
      cnt_q       <= 3'd0;
      sub_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        hc_q    <= hc_d;
        sl_q    <= sl_d;
        ins_q   <= ins_d;
        phase_q <= next_phase(PH_START, open_d, pre_d, ml_d, post_d, close_d);
        cnt_q   <= 3'd0;
        sub_q   <= 2'd0;
      end else if (emit) begin
        if (ph_last) begin
          phase_q <= ph_after;
          cnt_q   <= 3'd0;
          sub_q   <= 2'd0;
        end else if (phase_q == PH_MAIN) begin
          cnt_q <= cnt_q + 3'd1;
        end else if (sub_q == 2'd2) begin
          sub_q <= 2'd0;
          cnt_q <= cnt_q + 3'd1;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load payload: held bytes, result plan, output byte
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        held_q[k] <= held_d[k];
      end
      for (int k = 0; k < jsesc_pkg::MAIN_DEPTH; k++) begin
        main_q[k] <= main_d[k];
      end
      open_q  <= open_d;
      pre_q   <= pre_d;
      ml_q    <= ml_d;
      post_q  <= post_d;
      close_q <= close_d;
    end
    if (emit) begin
      out_byte_q  <= emit_byte;
      out_last_q  <= ph_last & (ph_after == PH_IDLE);
      out_close_q <= (phase_q == PH_CLOSE);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_close_q;

endmodule

[tb/tb_json_string_escaper_utf8_unit.sv]
// Testbench for json_string_escaper_utf8_unit: directed and random strings in, JSON literal out.
// Predicts each escaped output byte and checks it; depends on jsesc_pkg and the escaper RTL.
module tb_json_string_escaper_utf8_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_ITEMS   = 310;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned STEP_MAX     = 16;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_in_run;
    logic       closes_string;
  } lit_byte_t;

  // Escaped-literal predictor with its own UTF-8 hold state
  class literal_tracker;
    logic [7:0]  seq_bytes[3];
    int unsigned seq_held;
    int unsigned seq_len;
    bit          str_open;
    lit_byte_t   step_bytes[$];
    lit_byte_t   expected_bytes[$];
    int unsigned errors;

    function new();
      seq_held = 0;
      seq_len  = 0;
      str_open = 0;
      errors   = 0;
    endfunction

    function void emit(logic [7:0] b, logic closing);
      lit_byte_t r;
      r.out_byte      = b;
      r.last_in_run   = 1'b0;
      r.closes_string = closing;
      if (step_bytes.size() < STEP_MAX) step_bytes.insert(step_bytes.size(), r);
    endfunction

    function void emit_fffd();
      emit(jsesc_pkg::REPL_B0, 1'b0);
      emit(jsesc_pkg::REPL_B1, 1'b0);
      emit(jsesc_pkg::REPL_B2, 1'b0);
    endfunction

    function logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return jsesc_pkg::CHAR_0 + {4'h0, nib};
      return 8'h61 + {4'h0, nib} - 8'd10;
    endfunction

    function void open_seq(logic [7:0] b, int unsigned len);
      seq_bytes[0] = b;
      seq_held     = 1;
      seq_len      = len;
    endfunction

    // Escape one byte that starts nothing held
    function void escape_byte(logic [7:0] b);
      if (b >= jsesc_pkg::PRINT_LO && b < jsesc_pkg::ASCII_END &&
          b != jsesc_pkg::QUOTE && b != jsesc_pkg::BSLASH) begin
        emit(b, 1'b0);
        return;
      end
      case (b)
        jsesc_pkg::QUOTE: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::QUOTE, 1'b0);
        end
        jsesc_pkg::BSLASH: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::BSLASH, 1'b0);
        end
        jsesc_pkg::CTL_BS: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::CHAR_B, 1'b0);
        end
        jsesc_pkg::CTL_FF: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::CHAR_F, 1'b0);
        end
        jsesc_pkg::CTL_LF: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::CHAR_N, 1'b0);
        end
        jsesc_pkg::CTL_CR: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::CHAR_R, 1'b0);
        end
        jsesc_pkg::CTL_HT: begin
          emit(jsesc_pkg::BSLASH, 1'b0); emit(jsesc_pkg::CHAR_T, 1'b0);
        end
        default: begin
          if (b < jsesc_pkg::PRINT_LO) begin
            emit(jsesc_pkg::BSLASH, 1'b0);
            emit(jsesc_pkg::CHAR_U, 1'b0);
            emit(jsesc_pkg::CHAR_0, 1'b0);
            emit(jsesc_pkg::CHAR_0, 1'b0);
            emit(hex_char(b[7:4]), 1'b0);
            emit(hex_char(b[3:0]), 1'b0);
          end else if (b >= jsesc_pkg::LEAD2_LO && b < jsesc_pkg::LEAD3_LO) begin
            open_seq(b, 2);
          end else if (b >= jsesc_pkg::LEAD3_LO && b < jsesc_pkg::LEAD4_LO) begin
            open_seq(b, 3);
          end else if (b >= jsesc_pkg::LEAD4_LO && b <= jsesc_pkg::LEAD4_HI) begin
            open_seq(b, 4);
          end else begin
            emit_fffd();
          end
        end
      endcase
    endfunction

    // Drop held bytes: each one turns into a replacement character
    function void flush_seq();
      repeat (seq_held) emit_fffd();
      seq_held = 0;
      seq_len  = 0;
    endfunction

    // Add a byte to a held sequence; rescan it if it breaks the sequence
    function void extend_seq(logic [7:0] b);
      bit ok;
      ok = (b[7:6] == 2'b10);
      if (ok && seq_held == 1) begin
        if (seq_bytes[0] == jsesc_pkg::LEAD3_LO && b < jsesc_pkg::CONT_A0) ok = 1'b0;
        if (seq_bytes[0] == jsesc_pkg::LEAD_ED && b >= jsesc_pkg::CONT_A0) ok = 1'b0;
        if (seq_bytes[0] == jsesc_pkg::LEAD4_LO && b < jsesc_pkg::CONT_90) ok = 1'b0;
        if (seq_bytes[0] == jsesc_pkg::LEAD4_HI && b >= jsesc_pkg::CONT_90) ok = 1'b0;
      end
      if (!ok) begin
        flush_seq();
        escape_byte(b);
      end else if (seq_held + 1 >= seq_len) begin
        for (int k = 0; k < seq_held; k++) emit(seq_bytes[k], 1'b0);
        emit(b, 1'b0);
        seq_held = 0;
        seq_len  = 0;
      end else begin
        seq_bytes[seq_held] = b;
        seq_held++;
      end
    endfunction

    // Note an accepted input transfer and queue the bytes it produces
    function void take_raw_byte(logic [7:0] data, logic has, logic eos);
      step_bytes.delete();
      if (!has && !eos) return;
      if (!str_open) begin
        emit(jsesc_pkg::QUOTE, 1'b0);
        str_open = 1;
        seq_held = 0;
        seq_len  = 0;
      end
      if (has) begin
        if (seq_held > 0) extend_seq(data);
        else escape_byte(data);
      end
      if (eos) begin
        flush_seq();
        emit(jsesc_pkg::QUOTE, 1'b1);
        str_open = 0;
      end
      if (step_bytes.size() > 0) step_bytes[step_bytes.size() - 1].last_in_run = 1'b1;
      foreach (step_bytes[i]) expected_bytes.insert(expected_bytes.size(), step_bytes[i]);
    endfunction

    // Compare an output transfer with the oldest predicted byte
    function void match_out_byte(logic [7:0] b, logic last, logic closes);
      lit_byte_t want;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output byte %02h", b);
        errors++;
        return;
      end
      want = expected_bytes.pop_front();
      if (want.out_byte !== b) begin
        $error("out_byte: expected %02h, got %02h", want.out_byte, b);
        errors++;
      end
      if (want.last_in_run !== last) begin
        $error("last_in_run: expected %0b, got %0b", want.last_in_run, last);
        errors++;
      end
      if (want.closes_string !== closes) begin
        $error("closes_string: expected %0b, got %0b", want.closes_string, closes);
        errors++;
      end
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tuser  = 1'b0;
  logic       s_tlast  = 1'b0;
  logic       m_tready = 1'b0;
  logic       s_tready;
  logic       m_tvalid;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  literal_tracker sb = new();

  int unsigned burst_left  = 0;
  int unsigned rx_mode     = 0;
  int unsigned rx_left     = 0;
  int unsigned rx_cyc      = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  str_bytes[$];

  json_string_escaper_utf8_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),   // [7:0] data_byte
    .s_axis_tuser_i (s_tuser),   // [0] has_byte
    .s_axis_tlast_i (s_tlast),   // end_of_string
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),   // [7:0] out_byte
    .m_axis_tuser_o (m_tuser),   // [0] closes_string
    .m_axis_tlast_o (m_tlast)    // last_in_run
  );

  always #5 clk = ~clk;

  // Send one item; insert a random gap at the end of each burst
  task automatic drive_item(input logic [7:0] d, input logic has, input logic eos);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= has;
    s_tlast  <= eos;
    do @(posedge clk); while (!s_tready);
    sb.take_raw_byte(d, has, eos);
    burst_left--;
  endtask

  // Append one random character, mostly well-formed UTF-8, some broken or noise
  function automatic void add_char();
    int unsigned kind;
    int unsigned len;
    int unsigned keep;
    logic [7:0]  seq[4];
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      str_bytes.insert(str_bytes.size(), 8'($urandom_range(8'h20, 8'h7F)));
    end else if (kind < 40) begin
      case ($urandom_range(0, 5))
        0:       str_bytes.insert(str_bytes.size(), jsesc_pkg::QUOTE);
        1:       str_bytes.insert(str_bytes.size(), jsesc_pkg::BSLASH);
        default: str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 8'h1F)));
      endcase
    end else if (kind < 93) begin
      len = (kind < 55) ? 2 : (kind < 70) ? 3 : (kind < 85) ? 4 : $urandom_range(2, 4);
      case (len)
        2:       seq[0] = 8'($urandom_range(jsesc_pkg::LEAD2_LO, 8'hDF));
        3:       seq[0] = 8'($urandom_range(jsesc_pkg::LEAD3_LO, 8'hEF));
        default: seq[0] = 8'($urandom_range(jsesc_pkg::LEAD4_LO, jsesc_pkg::LEAD4_HI));
      endcase
      for (int k = 1; k < 4; k++) seq[k] = 8'h80 | 8'($urandom_range(0, 63));
      // keep the second byte inside the range its lead allows
      if (seq[0] == jsesc_pkg::LEAD3_LO) seq[1] = jsesc_pkg::CONT_A0 | 8'($urandom_range(0, 31));
      if (seq[0] == jsesc_pkg::LEAD_ED)  seq[1] = 8'h80 | 8'($urandom_range(0, 31));
      if (seq[0] == jsesc_pkg::LEAD4_LO) seq[1] = jsesc_pkg::CONT_90 + 8'($urandom_range(0, 47));
      if (seq[0] == jsesc_pkg::LEAD4_HI) seq[1] = 8'h80 | 8'($urandom_range(0, 15));
      keep = (kind >= 85) ? $urandom_range(1, len - 1) : len;
      for (int k = 0; k < keep; k++) str_bytes.insert(str_bytes.size(), seq[k]);
    end else begin
      str_bytes.insert(str_bytes.size(), 8'($urandom_range(0, 255)));
    end
  endfunction

  // Output side: check transfers and stall on a changing pattern
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.match_out_byte(m_tdata, m_tlast, m_tuser);
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    rx_cyc++;
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (rx_cyc % 3) != 0;
      default: m_tready <= (rx_cyc % 8) == 0;
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned items;
    bit          sep_end;
    items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // No-op item, then an empty string
    drive_item(8'hA5, 1'b0, 1'b0);
    drive_item(8'h5A, 1'b0, 1'b1);

    // Escapes, extremes, bad leads, each early failure, stray and truncated bytes
    str_bytes = {8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, jsesc_pkg::QUOTE, jsesc_pkg::BSLASH,
                 jsesc_pkg::CTL_BS, jsesc_pkg::CTL_FF, jsesc_pkg::CTL_LF,
                 jsesc_pkg::CTL_CR, jsesc_pkg::CTL_HT, 8'hFF,
                 jsesc_pkg::LEAD3_LO, 8'h9F, jsesc_pkg::LEAD_ED, jsesc_pkg::CONT_A0,
                 jsesc_pkg::LEAD4_LO, 8'h8F, jsesc_pkg::LEAD4_HI, jsesc_pkg::CONT_90,
                 jsesc_pkg::LEAD2_LO, 8'h41, 8'h80, 8'hC1, 8'hE2, 8'h82};
    foreach (str_bytes[i]) drive_item(str_bytes[i], 1'b1, 1'b0);
    // end mark without a byte flushes the truncated sequence
    drive_item(8'h00, 1'b0, 1'b1);

    // Random strings
    while (items < RAND_ITEMS) begin
      str_bytes.delete();
      if ($urandom_range(0, 19) != 0) repeat ($urandom_range(1, 10)) add_char();
      sep_end = (str_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
      foreach (str_bytes[i]) begin
        if ($urandom_range(0, 24) == 0) drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        drive_item(str_bytes[i], 1'b1, !sep_end && (i == str_bytes.size() - 1));
        items++;
      end
      if (sep_end) begin
        drive_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        items++;
      end
    end

    // Drain and settle
    s_tvalid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
